// ===== rtl/tisrch_pkg.sv =====
// ----------------------------------------------------------------------------
// tisrch_pkg
// shared widths, function codes and conversion weights for the time interval
// table search unit
// ----------------------------------------------------------------------------
package tisrch_pkg;

    // default table size
    localparam int unsigned TABLE_DEPTH_DEF = 1024;

    // field widths
    localparam int unsigned MS_W       = 29;
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned CNT_W      = 11;
    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned HOURS_W    = 7;
    localparam int unsigned MINUTES_W  = 6;
    localparam int unsigned SECONDS_W  = 6;
    localparam int unsigned MILLIS_W   = 10;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 16;

    // conversion unit
    localparam int unsigned DIGIT_W  = 10;
    localparam int unsigned WEIGHT_W = 22;
    localparam int unsigned STEP_W   = 2;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_WR_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_END   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 2'd2;

    // conversion steps, one field each
    localparam logic [STEP_W-1:0] STEP_HOURS   = 2'd0;
    localparam logic [STEP_W-1:0] STEP_MINUTES = 2'd1;
    localparam logic [STEP_W-1:0] STEP_SECONDS = 2'd2;
    localparam logic [STEP_W-1:0] STEP_MILLIS  = 2'd3;

    // milliseconds per unit of the field handled in a step
    function automatic logic [WEIGHT_W-1:0] conv_weight(input logic [STEP_W-1:0] step);
        logic [WEIGHT_W-1:0] w;
        unique case (step)
            STEP_HOURS:   w = 22'd3600000;
            STEP_MINUTES: w = 22'd60000;
            STEP_SECONDS: w = 22'd1000;
            STEP_MILLIS:  w = 22'd1;
            default:      w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/tisrch_ram.sv =====
// ----------------------------------------------------------------------------
// tisrch_ram
// generic simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module tisrch_ram
    import tisrch_pkg::*;
#(
    parameter int unsigned WIDTH = MS_W,
    parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/time_interval_table_search_unit.sv =====
// ----------------------------------------------------------------------------
// time_interval_table_search_unit
// interval table with time lookup by cached check and binary search
//
// Keeps a table of [start, end] intervals in milliseconds and answers, for a
// time given as hours, minutes, seconds and milliseconds, which of the first
// entry_count entries holds it. A word with tuser 0 or 1 writes the start or
// the end of entry entry_index and gives no result; tuser 2 looks a time up
// and gives one result word with the entry index, or 0 when no entry holds
// the time; tuser 3 is dropped. The last hit interval, or entry 0 after a
// miss, is cached; a time inside it answers without a search. One word is
// handled at a time: s_axis_tready is high only while the unit is idle.
// Every word is accepted and turned into milliseconds by the shared
// multiply-accumulate, one stamp field at a time. A load then writes its
// entry. A lookup does the cache check, then one probe of the binary search
// at a time (up to 11 probes at 1024 entries), on a miss one more read to
// fetch entry 0 for the cache, and last hands the result to the output
// register. The hand-off waits while the output register still holds a
// word that has not been taken. The probe rate is set by the one read port
// of the interval memories. The output register lets a result wait while
// the next word is taken.
// ----------------------------------------------------------------------------
module time_interval_table_search_unit
    import tisrch_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration: entry_count
    input  logic                  i_cfg_we,
    input  logic [CNT_W-1:0]      i_cfg_wdata,

    // input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_index[9:0], hours[16:10], minutes[22:17], seconds[28:23],
    // millis[38:29], zero pad[39]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]     s_axis_tuser,

    // result words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // section_index[9:0], zero pad[15:10]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // address width of the table and width of the search bounds, which
    // must also hold the table depth itself
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_WRITE,
        ST_CHECK,
        ST_SRCH,
        ST_MISS,
        ST_OUT
    } t_state;

    t_state r_state;

    // latched input word
    logic [FUNC_W-1:0]    r_func;
    logic [IDX_W-1:0]     r_idx;
    logic [HOURS_W-1:0]   r_hours;
    logic [MINUTES_W-1:0] r_minutes;
    logic [SECONDS_W-1:0] r_seconds;
    logic [MILLIS_W-1:0]  r_millis;

    // conversion accumulator, holds the time in ms once converted
    logic [STEP_W-1:0] r_step;
    logic [MS_W-1:0]   r_acc;
    logic [MS_W-1:0]   n_acc;

    // configuration and cache
    logic [CNT_W-1:0] r_entry_count;
    logic [MS_W-1:0]  r_cached_start_ms;
    logic [MS_W-1:0]  r_cached_end_ms;
    logic [IDX_W-1:0] r_cached_index;

    // search bounds: lo inclusive, hix one past the upper bound
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hix;
    logic [AW-1:0] r_mid;
    logic [CW-1:0] n_lo;
    logic [CW-1:0] n_hix;
    logic [AW-1:0] n_mid;

    // result and output register
    logic [IDX_W-1:0] r_result;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_index;

    // conversion datapath
    logic [DIGIT_W-1:0]          w_digit;
    logic [WEIGHT_W-1:0]         w_weight;
    logic [DIGIT_W+WEIGHT_W-1:0] w_prod;

    // table access
    logic          w_idx_ok;
    logic          w_we_start;
    logic          w_we_end;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [MS_W-1:0] w_rd_start;
    logic [MS_W-1:0] w_rd_end;

    // search control
    logic [CW-1:0] w_n;
    logic          w_in_cache;
    logic          w_below;
    logic          w_above;
    logic [CW-1:0] w_lo_sel;
    logic [CW-1:0] w_hix_sel;
    logic [CW:0]   w_sum;
    logic          w_more;

    // ---------------------------------------------------------------------
    // shared multiply-accumulate: one stamp field per cycle
    // ---------------------------------------------------------------------
    always_comb begin
        unique case (r_step)
            STEP_HOURS:   w_digit = DIGIT_W'(r_hours);
            STEP_MINUTES: w_digit = DIGIT_W'(r_minutes);
            STEP_SECONDS: w_digit = DIGIT_W'(r_seconds);
            STEP_MILLIS:  w_digit = DIGIT_W'(r_millis);
            default:      w_digit = '0;
        endcase
    end

    assign w_weight = conv_weight(r_step);
    assign w_prod   = (DIGIT_W+WEIGHT_W)'(w_digit) * (DIGIT_W+WEIGHT_W)'(w_weight);
    assign n_acc    = r_acc + MS_W'(w_prod);

    // ---------------------------------------------------------------------
    // interval memories
    // ---------------------------------------------------------------------
    // loads beyond the table are dropped
    assign w_idx_ok   = (32'(r_idx) < TABLE_DEPTH);
    assign w_we_start = (r_state == ST_WRITE) && w_idx_ok && (r_func == FUNC_WR_START);
    assign w_we_end   = (r_state == ST_WRITE) && w_idx_ok && (r_func == FUNC_WR_END);
    assign w_waddr    = AW'(r_idx);

    tisrch_ram #(
        .WIDTH (MS_W),
        .DEPTH (TABLE_DEPTH)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_start),
        .i_waddr (w_waddr),
        .i_wdata (r_acc),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_start)
    );

    tisrch_ram #(
        .WIDTH (MS_W),
        .DEPTH (TABLE_DEPTH)
    ) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_end),
        .i_waddr (w_waddr),
        .i_wdata (r_acc),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_end)
    );

    // ---------------------------------------------------------------------
    // search step: compare the probed entry, narrow the bounds and issue the
    // next probe address in the same cycle
    // ---------------------------------------------------------------------
    // entry count saturates at the table depth
    assign w_n = (32'(r_entry_count) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(r_entry_count);

    // below start is tested first, also for a reversed interval
    assign w_in_cache = !(r_acc < r_cached_start_ms) && !(r_acc > r_cached_end_ms);
    assign w_below    = (r_acc < w_rd_start);
    assign w_above    = !w_below && (r_acc > w_rd_end);

    always_comb begin
        n_lo  = r_lo;
        n_hix = r_hix;
        if (w_below) begin
            n_hix = CW'(r_mid);
        end else if (w_above) begin
            n_lo = CW'(r_mid) + CW'(1);
        end
    end

    // the first probe starts from the full range
    assign w_lo_sel  = (r_state == ST_CHECK) ? '0  : n_lo;
    assign w_hix_sel = (r_state == ST_CHECK) ? w_n : n_hix;
    assign w_more    = (w_lo_sel < w_hix_sel);
    assign w_sum     = {1'b0, w_lo_sel} + {1'b0, w_hix_sel} - (CW+1)'(1);
    assign n_mid     = AW'(w_sum[CW:1]);

    // an empty range reads entry 0 to refill the cache on a miss
    assign w_raddr = w_more ? n_mid : '0;

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_out_valid       <= 1'b0;
            r_entry_count     <= CNT_W'(1);
            r_cached_start_ms <= '0;
            r_cached_end_ms   <= '0;
            r_cached_index    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end

            // result word taken; in the hand-off state the register is reloaded
            if (m_axis_tready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_func    <= s_axis_tuser;
                        r_idx     <= s_axis_tdata[9:0];
                        r_hours   <= s_axis_tdata[16:10];
                        r_minutes <= s_axis_tdata[22:17];
                        r_seconds <= s_axis_tdata[28:23];
                        r_millis  <= s_axis_tdata[38:29];
                        r_acc     <= '0;
                        r_step    <= STEP_HOURS;
                        r_state   <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_acc  <= n_acc;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_MILLIS) begin
                        priority if (r_func == FUNC_WR_START || r_func == FUNC_WR_END) begin
                            r_state <= ST_WRITE;
                        end else if (r_func == FUNC_LOOKUP) begin
                            r_state <= ST_CHECK;
                        end else begin
                            // unknown function, dropped
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_WRITE: begin
                    r_state <= ST_IDLE;
                end
                ST_CHECK: begin
                    if (w_in_cache) begin
                        r_result <= r_cached_index;
                        r_state  <= ST_OUT;
                    end else begin
                        r_lo    <= '0;
                        r_hix   <= w_n;
                        r_mid   <= n_mid;
                        r_state <= w_more ? ST_SRCH : ST_MISS;
                    end
                end
                ST_SRCH: begin
                    if (!w_below && !w_above) begin
                        // hit: cache the probed interval
                        r_cached_start_ms <= w_rd_start;
                        r_cached_end_ms   <= w_rd_end;
                        r_cached_index    <= IDX_W'(32'(r_mid));
                        r_result          <= IDX_W'(32'(r_mid));
                        r_state           <= ST_OUT;
                    end else begin
                        r_lo    <= n_lo;
                        r_hix   <= n_hix;
                        r_mid   <= n_mid;
                        r_state <= w_more ? ST_SRCH : ST_MISS;
                    end
                end
                ST_MISS: begin
                    // entry 0 was read in the previous cycle
                    r_cached_start_ms <= w_rd_start;
                    r_cached_end_ms   <= w_rd_end;
                    r_cached_index    <= '0;
                    r_result          <= '0;
                    r_state           <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_index <= r_result;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_index);

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    // every probe lies inside a non-empty search range
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH) |-> ((r_lo < r_hix) && (r_lo <= CW'(r_mid)) && (CW'(r_mid) < r_hix)))
        else $error("search probe outside its range");

    // the cache only changes at the end of a search
    a_cache_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SRCH && r_state != ST_MISS) |=>
            ($stable(r_cached_index) && $stable(r_cached_start_ms) && $stable(r_cached_end_ms)))
        else $error("cache changed outside a search");

    // a result word appears only from the hand-off state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_OUT))
        else $error("result word without a finished lookup");

endmodule
